### rtl/tgvm_pkg.sv
// tone generator voice mixer: shared types and constants
// used by tgvm_sine and tone_generator_voice_mixer_core; depends on nothing
package tgvm_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_WAVE_SHAPE    = 2'd0,
		CFG_PHASE_STEP    = 2'd1,
		CFG_SQUARE_PERIOD = 2'd2,
		CFG_VOLUME        = 2'd3
	} cfg_idx_t;

	// waveform select; code 3 behaves as silent
	typedef enum logic [1:0] {
		SHAPE_SINE   = 2'd0,
		SHAPE_SQUARE = 2'd1,
		SHAPE_SILENT = 2'd2
	} shape_t;

	// stage enables of the sine pipeline
	typedef struct packed {
		logic a;
		logic b;
		logic c;
		logic d;
	} sine_en_t;

	localparam int SHAPE_W  = 2;
	localparam int PERIOD_W = 16;
	localparam int VOLUME_W = 11;
	localparam int TONE_W   = 18;   // signed width of the halved sine

	// q16 sine polynomial constants
	localparam logic [16:0] SINE_ONE = 17'd65536;
	localparam logic [15:0] SINE_C1  = 16'd42047;
	localparam logic [12:0] SINE_C2  = 13'd4640;
	localparam logic [16:0] SINE_C3  = 17'd102944;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
	localparam logic [VOLUME_W-1:0] VOLUME_UNITY = 11'd256;

endpackage

### rtl/tone_generator_voice_mixer_core.sv
// tone generator voice mixer: top level with config registers, position and mix pipeline
// depends on tgvm_pkg and tgvm_sine
//
// use of the block
//  - input channel: one item is one mix sample (mix_in), taken on in_valid and in_ready
//  - output channel: one item out for every item in, mix_out on out_valid and out_ready
//  - config port: cfg_we writes cfg_data into register cfg_index; the user must
//    write only while the pipeline is empty, which the block leaves unchecked;
//    shape and period writes restart the wave
//  - pipeline: six stages, s1 to s6; out_valid is the valid bit of stage six
//  - throughput: one item per cycle while out_ready is high; the wave position is
//    updated at acceptance, so back-to-back items never wait on each other
//  - the sine polynomial runs over four pipeline stages (one multiply each),
//    the volume multiply and saturating add sit in the final stage
//  - a stalled receiver holds the output register; each stage keeps loading
//    while a later stage has room, so bubbles close up before in_ready drops
//  - reset clears all valid bits and the position, and loads the register defaults
//    (sine, step zero, period 100, unity volume)
module tone_generator_voice_mixer_core import tgvm_pkg::*; #(
	parameter int PHASE_BITS  = 18,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] mix_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] mix_out,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [((PHASE_BITS > PERIOD_W) ? PHASE_BITS : PERIOD_W)-1:0] cfg_data
);

	// position holds either the sine phase or the square count
	localparam int PW  = (PHASE_BITS > PERIOD_W) ? PHASE_BITS : PERIOD_W;
	localparam int TT  = (TONE_W > SAMPLE_BITS) ? TONE_W : SAMPLE_BITS;
	localparam int PRW = TT + VOLUME_W + 1;
	localparam int SW  = PRW + 1;

	// configuration registers
	shape_t                wave_shape_q;
	logic [PHASE_BITS-1:0] phase_step_q;
	logic [PERIOD_W-1:0]   square_period_q;
	logic [VOLUME_W-1:0]   volume_q;
	logic [PW-1:0]         wave_position_q;

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;
	logic accept;

	// payload
	logic signed [SAMPLE_BITS-1:0] mix_s1, mix_s2, mix_s3, mix_s4, mix_s5;
	logic                          sq_hi_s2, sq_hi_s3, sq_hi_s4, sq_hi_s5;
	logic signed [SAMPLE_BITS-1:0] mix_out_s6;

	// position update
	logic [PERIOD_W-1:0]   period_eff;
	logic [PW:0]           pos_inc;
	logic [PHASE_BITS-1:0] phase_next;
	logic                  sq_hi;

	// final stage
	logic signed [TONE_W-1:0]      sine_tone;
	logic signed [TT-1:0]          tone_sel;
	logic signed [TT-1:0]          sq_tone;
	logic signed [PRW-1:0]         prod;
	logic signed [PRW-1:0]         scaled;
	logic signed [SW-1:0]          sum;
	logic                          ovf;
	logic signed [SAMPLE_BITS-1:0] sat;
	sine_en_t                      sine_en;

	// a stage loads whenever it is empty or the next one is moving
	assign adv6     = !v_s6 || out_ready;
	assign adv5     = !v_s5 || adv6;
	assign adv4     = !v_s4 || adv5;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;
	assign accept   = in_valid && adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_shape_q    <= SHAPE_SINE;
			phase_step_q    <= '0;
			square_period_q <= PERIOD_RESET;
			volume_q        <= VOLUME_UNITY;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WAVE_SHAPE:    wave_shape_q    <= shape_t'(cfg_data[SHAPE_W-1:0]);
				CFG_PHASE_STEP:    phase_step_q    <= cfg_data[PHASE_BITS-1:0];
				CFG_SQUARE_PERIOD: square_period_q <= cfg_data[PERIOD_W-1:0];
				CFG_VOLUME:        volume_q        <= cfg_data[VOLUME_W-1:0];
				default: ;
			endcase
		end
	end

	// a zero period counts as one
	assign period_eff = (square_period_q == '0) ? PERIOD_W'(1) : square_period_q;
	assign pos_inc    = (PW+1)'(wave_position_q) + (PW+1)'(1);
	assign phase_next = wave_position_q[PHASE_BITS-1:0] + phase_step_q;

	// position moves on acceptance; the square count stays below the period
	// because entering square mode or changing the period restarts it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_position_q <= '0;
		end else if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_WAVE_SHAPE ||
		                        cfg_idx_t'(cfg_index) == CFG_SQUARE_PERIOD)) begin
			wave_position_q <= '0;
		end else if (accept) begin
			case (wave_shape_q)
				SHAPE_SINE:   wave_position_q <= PW'(phase_next);
				SHAPE_SQUARE: wave_position_q <= (pos_inc >= (PW+1)'(period_eff)) ?
				                                 '0 : pos_inc[PW-1:0];
				default: ;
			endcase
		end
	end

	// stage one sees the updated position: first half of the period is low
	assign sq_hi = !({wave_position_q, 1'b0} < (PW+1)'(period_eff));

	assign sine_en.a = adv2;
	assign sine_en.b = adv3;
	assign sine_en.c = adv4;
	assign sine_en.d = adv5;

	tgvm_sine #(
		.PHASE_BITS(PHASE_BITS)
	) u_sine (
		.clk   (clk),
		.en    (sine_en),
		.phase (wave_position_q[PHASE_BITS-1:0]),
		.tone  (sine_tone)
	);

	always_ff @(posedge clk) begin
		if (adv1) mix_s1 <= mix_in;
		if (adv2) begin
			mix_s2   <= mix_s1;
			sq_hi_s2 <= sq_hi;
		end
		if (adv3) begin
			mix_s3   <= mix_s2;
			sq_hi_s3 <= sq_hi_s2;
		end
		if (adv4) begin
			mix_s4   <= mix_s3;
			sq_hi_s4 <= sq_hi_s3;
		end
		if (adv5) begin
			mix_s5   <= mix_s4;
			sq_hi_s5 <= sq_hi_s4;
		end
		if (adv6) mix_out_s6 <= sat;
	end

	// square tone is the sample range extremes
	assign sq_tone = sq_hi_s5 ? TT'($signed({1'b0, {(SAMPLE_BITS-1){1'b1}}}))
	                          : TT'($signed({1'b1, {(SAMPLE_BITS-1){1'b0}}}));

	always_comb begin
		case (wave_shape_q)
			SHAPE_SINE:   tone_sel = TT'(sine_tone);
			SHAPE_SQUARE: tone_sel = sq_tone;
			default:      tone_sel = '0;
		endcase
	end

	// q8 volume, floor via arithmetic shift, then saturating add
	assign prod   = PRW'(tone_sel) * PRW'($signed({1'b0, volume_q}));
	assign scaled = prod >>> 8;
	assign sum    = SW'(scaled) + SW'(mix_s5);
	assign ovf    = !((&sum[SW-1:SAMPLE_BITS-1]) || !(|sum[SW-1:SAMPLE_BITS-1]));
	assign sat    = !ovf ? sum[SAMPLE_BITS-1:0] :
	                sum[SW-1] ? $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}}) :
	                            $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});

	assign out_valid = v_s6;
	assign mix_out   = mix_out_s6;

endmodule

### rtl/tgvm_sine.sv
// tone generator voice mixer: four-stage q16 sine from a phase, halved
// depends on tgvm_pkg
module tgvm_sine import tgvm_pkg::*; #(
	parameter int PHASE_BITS = 18
) (
	input  logic                     clk,
	input  sine_en_t                 en,
	input  logic [PHASE_BITS-1:0]    phase,
	output logic signed [TONE_W-1:0] tone
);

	localparam int FB = PHASE_BITS - 2;

	logic [1:0]      quad;
	logic [FB+15:0]  z_wide;
	logic [16:0]     z_raw;
	logic [16:0]     z;
	logic [33:0]     zsq;
	logic [29:0]     m1;
	logic [32:0]     m2;
	logic [33:0]     m3;
	logic [17:0]     r;
	logic [16:0]     r_clip;
	logic signed [TONE_W-1:0] r_signed;

	logic [16:0] z_a, z2_a, z_b, z2_b, z_c, u_c;
	logic [15:0] t_b;
	logic [1:0]  quad_a, quad_b, quad_c;
	logic signed [TONE_W-1:0] tone_d;

	// quarter-turn fraction scaled to q16, mirrored in odd quadrants
	assign quad   = phase[PHASE_BITS-1 -: 2];
	assign z_wide = {phase[FB-1:0], 16'd0} >> FB;
	assign z_raw  = z_wide[16:0];
	assign z      = quad[0] ? (SINE_ONE - z_raw) : z_raw;
	assign zsq    = z * z;

	assign m1 = z2_a * SINE_C2;
	assign m2 = z2_b * t_b;
	assign m3 = z_c * u_c;

	assign r        = m3[33:16];
	assign r_clip   = (r > 18'(SINE_ONE)) ? SINE_ONE : r[16:0];
	assign r_signed = quad_c[1] ? -$signed(TONE_W'(r_clip)) : $signed(TONE_W'(r_clip));

	always_ff @(posedge clk) begin
		if (en.a) begin
			z_a    <= z;
			z2_a   <= zsq[32:16];
			quad_a <= quad;
		end
		if (en.b) begin
			z_b    <= z_a;
			z2_b   <= z2_a;
			t_b    <= SINE_C1 - 16'(m1[29:16]);
			quad_b <= quad_a;
		end
		if (en.c) begin
			z_c    <= z_b;
			u_c    <= SINE_C3 - m2[32:16];
			quad_c <= quad_b;
		end
		if (en.d) begin
			tone_d <= r_signed >>> 1;
		end
	end

	assign tone = tone_d;

endmodule
